FILE: rtl/bfta_pkg.sv
// Shared types, widths, register codes and a saturating-add helper for the body force/torque block.
package bfta_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned CRD_W         = 32;
  localparam int unsigned DIST_W        = CRD_W + 1;
  localparam int unsigned ACC_W         = 64;
  localparam int unsigned FILL_W        = 16;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned NUM_LANES     = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BODY_POS_X  = 3'd0,
    CFG_BODY_POS_Y  = 3'd1,
    CFG_BODY_POS_Z  = 3'd2,
    CFG_UNIT_FACTOR = 3'd3
  } cfg_idx_e;

  typedef logic signed [CRD_W-1:0] crd_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  // One accepted cell
  typedef struct packed {
    crd_t [2:0] pos;
    crd_t [2:0] frc;
    logic       act;
    logic       last;
  } cell_t;

  // Force and torque contribution of one cell
  typedef struct packed {
    crd_t [2:0] frc;
    acc_t [2:0] torque;
    logic       act;
    logic       last;
  } term_t;

  // Six running or scaled totals
  typedef struct packed {
    acc_t [2:0] frc;
    acc_t [2:0] torque;
  } sums_t;

  // Signed add that clamps at the 64-bit limits
  function automatic acc_t sat_add(acc_t a, acc_t b);
    acc_t s;
    s = a + b;
    if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
      s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s;
  endfunction

endpackage

FILE: rtl/body_force_torque_accumulator.sv
// Top level: configuration registers and the cell-to-total force/torque pipeline.
//
//   channel   direction  handshake                 payload
//   cell in   input      in_valid_i / in_ready_o   cell_x/y/z, force_x/y/z, fill_fraction, last_cell
//   total out output     out_valid_o / out_ready_i total_force_x/y/z, total_torque_x/y/z
//   config    input      cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// One cell is taken per cycle while in_ready_o is high; the saturating 64-bit add of the
// accumulator register closes the only loop. A last cell's totals pass through 4 term stages,
// the snapshot and 4 scaler stages, the first term stage loaded at the accepting edge; the
// 33x32 and 32x32 multipliers are each registered.
// Reset clears the sums, the valid bits and the body position, and sets unit_factor to 1.0.
// A held result first fills the scaler stages, then the snapshot; only a further last
// cell then stops the stream, and the stall runs back to in_ready_o.
module body_force_torque_accumulator #(
  parameter int unsigned FRAC_BITS = bfta_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bfta_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bfta_pkg::CRD_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [bfta_pkg::CRD_W-1:0] cell_x_i,
  input  logic signed [bfta_pkg::CRD_W-1:0] cell_y_i,
  input  logic signed [bfta_pkg::CRD_W-1:0] cell_z_i,
  input  logic signed [bfta_pkg::CRD_W-1:0] force_x_i,
  input  logic signed [bfta_pkg::CRD_W-1:0] force_y_i,
  input  logic signed [bfta_pkg::CRD_W-1:0] force_z_i,
  input  logic [bfta_pkg::FILL_W-1:0]     fill_fraction_i,
  input  logic                            last_cell_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [bfta_pkg::ACC_W-1:0] total_force_x_o,
  output logic signed [bfta_pkg::ACC_W-1:0] total_force_y_o,
  output logic signed [bfta_pkg::ACC_W-1:0] total_force_z_o,
  output logic signed [bfta_pkg::ACC_W-1:0] total_torque_x_o,
  output logic signed [bfta_pkg::ACC_W-1:0] total_torque_y_o,
  output logic signed [bfta_pkg::ACC_W-1:0] total_torque_z_o
);

  localparam logic [bfta_pkg::CRD_W-1:0] UnitOne = bfta_pkg::CRD_W'(1) << FRAC_BITS;

  bfta_pkg::crd_t [2:0]         pos_q;
  logic [bfta_pkg::CRD_W-1:0]   unit_q;
  bfta_pkg::cell_t              cell_item;
  logic                         term_valid, term_ready;
  bfta_pkg::term_t              term_item;
  logic                         snap_valid, snap_ready;
  bfta_pkg::sums_t              snap_sums;
  bfta_pkg::sums_t              out_sums;

  // Register writes; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      unit_q <= UnitOne;
    end else if (cfg_we_i) begin
      unique case (bfta_pkg::cfg_idx_e'(cfg_idx_i))
        bfta_pkg::CFG_BODY_POS_X:  pos_q[0] <= cfg_data_i;
        bfta_pkg::CFG_BODY_POS_Y:  pos_q[1] <= cfg_data_i;
        bfta_pkg::CFG_BODY_POS_Z:  pos_q[2] <= cfg_data_i;
        bfta_pkg::CFG_UNIT_FACTOR: unit_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pack the incoming cell item
  assign cell_item.pos  = {cell_z_i, cell_y_i, cell_x_i};
  assign cell_item.frc  = {force_z_i, force_y_i, force_x_i};
  assign cell_item.act  = |fill_fraction_i;
  assign cell_item.last = last_cell_i;

  bfta_term #(
    .FRAC_BITS (FRAC_BITS)
  ) u_term (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .body_pos_i  (pos_q),
    .in_valid_i  (in_valid_i),
    .in_item_i   (cell_item),
    .in_ready_o  (in_ready_o),
    .out_valid_o (term_valid),
    .out_item_o  (term_item),
    .out_ready_i (term_ready)
  );

  bfta_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (term_valid),
    .in_item_i   (term_item),
    .in_ready_o  (term_ready),
    .out_valid_o (snap_valid),
    .out_sums_o  (snap_sums),
    .out_ready_i (snap_ready)
  );

  bfta_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .unit_factor_i (unit_q),
    .in_valid_i    (snap_valid),
    .in_sums_i     (snap_sums),
    .in_ready_o    (snap_ready),
    .out_valid_o   (out_valid_o),
    .out_sums_o    (out_sums),
    .out_ready_i   (out_ready_i)
  );

  // Unpack the result item
  assign total_force_x_o  = out_sums.frc[0];
  assign total_force_y_o  = out_sums.frc[1];
  assign total_force_z_o  = out_sums.frc[2];
  assign total_torque_x_o = out_sums.torque[0];
  assign total_torque_y_o = out_sums.torque[1];
  assign total_torque_z_o = out_sums.torque[2];

endmodule

FILE: rtl/bfta_term.sv
// Per-cell datapath: distance to body centre, cross-product partials and torque terms.
module bfta_term #(
  parameter int unsigned FRAC_BITS = bfta_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bfta_pkg::crd_t [2:0]   body_pos_i,
  input  logic                   in_valid_i,
  input  bfta_pkg::cell_t        in_item_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  output bfta_pkg::term_t        out_item_o,
  input  logic                   out_ready_i
);

  localparam int unsigned CW = bfta_pkg::CRD_W;
  localparam int unsigned DW = bfta_pkg::DIST_W;
  localparam int unsigned AW = bfta_pkg::ACC_W;
  localparam int unsigned PW = DW + CW;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  bfta_pkg::cell_t            s1_q;
  logic signed [DW-1:0]       d_d [3];
  logic signed [DW-1:0]       d_q [3];
  bfta_pkg::crd_t [2:0]       f2_q, f3_q;
  logic                       act2_q, last2_q, act3_q, last3_q;
  logic signed [AW-1:0]       p_d [6];
  logic signed [AW-1:0]       p_q [6];
  bfta_pkg::term_t            s4_d, s4_q;

  // Advance a stage when it is empty or its successor moves
  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Distance from body centre, exact in one extra bit
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d_d[a] = $signed({s1_q.pos[a][CW-1], s1_q.pos[a]})
             - $signed({body_pos_i[a][CW-1], body_pos_i[a]});
    end
  end

  // Cross-product partials and floored torque terms
  for (genvar a = 0; a < 3; a++) begin : g_axis
    localparam int unsigned B = (a + 1) % 3;
    localparam int unsigned C = (a + 2) % 3;
    logic signed [PW-1:0] prod_pos, prod_neg;
    assign prod_pos   = d_q[B] * $signed(f2_q[C]);
    assign prod_neg   = d_q[C] * $signed(f2_q[B]);
    assign p_d[2*a]   = prod_pos[AW-1:0];
    assign p_d[2*a+1] = prod_neg[AW-1:0];
    assign s4_d.torque[a] = (p_q[2*a] >>> FRAC_BITS) - (p_q[2*a+1] >>> FRAC_BITS);
  end

  assign s4_d.frc  = f3_q;
  assign s4_d.act  = act3_q;
  assign s4_d.last = last3_q;

  // Payload registers follow their valid bits
  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy1) begin
      s1_q <= in_item_i;
    end
    if (v1_q && rdy2) begin
      d_q     <= d_d;
      f2_q    <= s1_q.frc;
      act2_q  <= s1_q.act;
      last2_q <= s1_q.last;
    end
    if (v2_q && rdy3) begin
      p_q     <= p_d;
      f3_q    <= f2_q;
      act3_q  <= act2_q;
      last3_q <= last2_q;
    end
    if (v3_q && rdy4) begin
      s4_q <= s4_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_item_o  = s4_q;

endmodule

FILE: rtl/bfta_accum.sv
// Running force and torque sums with a snapshot taken on the last cell of a sweep.
module bfta_accum (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  bfta_pkg::term_t  in_item_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output bfta_pkg::sums_t  out_sums_o,
  input  logic             out_ready_i
);

  bfta_pkg::sums_t sum_q, sum_d, upd;
  bfta_pkg::sums_t snap_q;
  logic            snap_v_q;
  logic            accept;

  // A last cell waits only while the previous snapshot is still held
  assign in_ready_o = !in_item_i.last || !snap_v_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Add this cell when it holds solid
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      upd.frc[a]    = in_item_i.act
                    ? bfta_pkg::sat_add(sum_q.frc[a], bfta_pkg::acc_t'(in_item_i.frc[a]))
                    : sum_q.frc[a];
      upd.torque[a] = in_item_i.act
                    ? bfta_pkg::sat_add(sum_q.torque[a], in_item_i.torque[a])
                    : sum_q.torque[a];
    end
    sum_d = sum_q;
    if (accept) begin
      sum_d = in_item_i.last ? '0 : upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      snap_v_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      if (accept && in_item_i.last) begin
        snap_v_q <= 1'b1;
      end else if (out_ready_i) begin
        snap_v_q <= 1'b0;
      end
    end
  end

  // Capture the closing totals
  always_ff @(posedge clk_i) begin
    if (accept && in_item_i.last) begin
      snap_q <= upd;
    end
  end

  assign out_valid_o = snap_v_q;
  assign out_sums_o  = snap_q;

endmodule

FILE: rtl/bfta_scale.sv
// Six-lane unit-factor scaler: magnitude, split multiply, combine and saturate.
module bfta_scale #(
  parameter int unsigned FRAC_BITS = bfta_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bfta_pkg::CRD_W-1:0]  unit_factor_i,
  input  logic                        in_valid_i,
  input  bfta_pkg::sums_t             in_sums_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  output bfta_pkg::sums_t             out_sums_o,
  input  logic                        out_ready_i
);

  localparam int unsigned CW = bfta_pkg::CRD_W;
  localparam int unsigned AW = bfta_pkg::ACC_W;
  localparam int unsigned NL = bfta_pkg::NUM_LANES;
  localparam int unsigned SH = CW - FRAC_BITS;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [NL-1:0][AW-1:0] in_lane;
  logic [NL-1:0][AW-1:0] out_lane;

  assign in_lane    = in_sums_i;
  assign out_sums_o = out_lane;

  // Advance a stage when it is empty or its successor moves
  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_lane
    logic [AW-1:0] mag_d, mag_q;
    logic          neg1_q, neg2_q, neg3_q;
    logic [AW-1:0] hi_prod_q, lo_prod_q;
    logic [AW:0]   comb_d;
    logic          ovf_d, ovf_q;
    logic [AW-1:0] r_q;
    logic          over;
    logic [AW-1:0] res_d, res_q;

    // Take the magnitude; the most negative sum maps to 2^63
    assign mag_d = in_lane[l][AW-1] ? (~in_lane[l] + 1'b1) : in_lane[l];

    // Shift the high partial into place and add the scaled low partial
    assign comb_d = {1'b0, hi_prod_q << SH} + {1'b0, lo_prod_q >> FRAC_BITS};
    assign ovf_d  = (|hi_prod_q[AW-1 -: SH]) || comb_d[AW];

    // Clamp to the signed range and restore the sign
    assign over  = ovf_q || (neg3_q ? (r_q[AW-1] && (|r_q[AW-2:0])) : r_q[AW-1]);
    always_comb begin
      if (over) begin
        res_d = neg3_q ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
      end else begin
        res_d = neg3_q ? (~r_q + 1'b1) : r_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (in_valid_i && rdy1) begin
        mag_q  <= mag_d;
        neg1_q <= in_lane[l][AW-1];
      end
      if (v1_q && rdy2) begin
        hi_prod_q <= AW'(mag_q[AW-1:CW] * unit_factor_i);
        lo_prod_q <= AW'(mag_q[CW-1:0] * unit_factor_i);
        neg2_q    <= neg1_q;
      end
      if (v2_q && rdy3) begin
        r_q    <= comb_d[AW-1:0];
        ovf_q  <= ovf_d;
        neg3_q <= neg2_q;
      end
      if (v3_q && rdy4) begin
        res_q <= res_d;
      end
    end

    assign out_lane[l] = res_q;
  end

  assign out_valid_o = v4_q;

endmodule
